[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define QRM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define QRM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/qrm_pkg.sv]
// ---------------------------------------------------------------------------
// qrm_pkg
// Types and constants shared by the quaternion to rotation matrix pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package qrm_pkg;

  localparam int unsigned QONE     = 16384;
  localparam int unsigned QBITS    = 15;
  localparam int unsigned NENT     = 9;
  localparam int unsigned NUMW     = 35;
  localparam int unsigned NORMW    = 33;
  localparam int unsigned REMW     = 49;
  localparam int unsigned DIVW     = 34;
  localparam int unsigned NSTAGE   = 19;
  localparam int unsigned DIVFIRST = 3;

  typedef struct packed {
    logic signed [31:0] xx, yy, zz, ww, xy, xz, xw, yz, yw, zw;
    logic               degen;
  } prod_t;

  typedef struct packed {
    logic [NORMW-1:0]           n;
    logic [NENT-1:0][NUMW-1:0]  num;
    logic                       degen;
  } numer_t;

  typedef struct packed {
    logic [NENT-1:0][REMW-1:0]  rem;
    logic [NENT-1:0][QBITS-1:0] q;
    logic [NENT-1:0]            neg;
    logic [DIVW-1:0]            d;
    logic                       degen;
  } div_t;

endpackage

`default_nettype wire

[src/quaternion_to_rotation_matrix.sv]
// Throughput: one quaternion per cycle unless the output stalls; the pipeline
// depth is set by the fifteen one-bit restoring division stages, nine lanes each.
// A stage holds only while the stage after it is full and stalled.
// Reset (rst_n low, synchronous) clears every stage valid bit; data needs none.
// ---------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Converts a quaternion of any common scale into a normalised 3x3 rotation
// matrix in signed Q1.14, with a flag for a zero-length input.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module quaternion_to_rotation_matrix (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_quat_x,
  input  wire logic signed [15:0] in_quat_y,
  input  wire logic signed [15:0] in_quat_z,
  input  wire logic signed [15:0] in_quat_w,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_r00,
  output logic signed [15:0]      out_r01,
  output logic signed [15:0]      out_r02,
  output logic signed [15:0]      out_r10,
  output logic signed [15:0]      out_r11,
  output logic signed [15:0]      out_r12,
  output logic signed [15:0]      out_r20,
  output logic signed [15:0]      out_r21,
  output logic signed [15:0]      out_r22,
  output logic                    out_degenerate
);

  localparam int unsigned NS = qrm_pkg::NSTAGE;

  // Stage map: 0 products, 1 numerators, 2 dividend setup, 3 to 17 division
  // (quotient bit 14 first), 18 output formatting and result register.
  logic [NS-1:0] valid_r, valid_nxt, rdy;

  qrm_pkg::prod_t  prod;
  qrm_pkg::numer_t numer;
  qrm_pkg::div_t   div_s [qrm_pkg::QBITS+1];
  logic [qrm_pkg::NENT-1:0][15:0] ent;

  // Each stage may load when it is empty or its contents move on. The chain
  // runs from the result end, so bubbles anywhere in the pipe are squeezed
  // out while the result register waits for its transfer.
  always_comb begin
    rdy[NS-1] = !valid_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
    valid_nxt[0] = rdy[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid_r[NS-1];

  qrm_prod u_prod (
    .clk    (clk),
    .en     (rdy[0]),
    .x      (in_quat_x),
    .y      (in_quat_y),
    .z      (in_quat_z),
    .w      (in_quat_w),
    .prod_r (prod)
  );

  qrm_numer u_numer (
    .clk     (clk),
    .en      (rdy[1]),
    .prod    (prod),
    .numer_r (numer)
  );

  qrm_prep u_prep (
    .clk   (clk),
    .en    (rdy[2]),
    .numer (numer),
    .div_r (div_s[0])
  );

  for (genvar g = 0; g < qrm_pkg::QBITS; g++) begin : g_div
    qrm_div_stage #(
      .Bit (qrm_pkg::QBITS - 1 - g)
    ) u_div (
      .clk   (clk),
      .en    (rdy[qrm_pkg::DIVFIRST + g]),
      .div_i (div_s[g]),
      .div_r (div_s[g+1])
    );
  end

  qrm_out u_out (
    .clk     (clk),
    .en      (rdy[NS-1]),
    .div_i   (div_s[qrm_pkg::QBITS]),
    .ent_r   (ent),
    .degen_r (out_degenerate)
  );

  assign out_r00 = $signed(ent[0]);
  assign out_r01 = $signed(ent[1]);
  assign out_r02 = $signed(ent[2]);
  assign out_r10 = $signed(ent[3]);
  assign out_r11 = $signed(ent[4]);
  assign out_r12 = $signed(ent[5]);
  assign out_r20 = $signed(ent[6]);
  assign out_r21 = $signed(ent[7]);
  assign out_r22 = $signed(ent[8]);

  // An empty result register frees the whole ready chain.
  `QRM_ASSERT_IMP(a_empty_ready, !out_valid, in_ready)
  // An input transfer always lands in the first stage.
  `QRM_ASSERT_NXT(a_in_lands, in_valid && in_ready, valid_r[0])
  // A degenerate result carries an all-zero matrix.
  `QRM_ASSERT_IMP(a_degen_zero, out_valid && out_degenerate,
                  ent == '0)
  // The entries r00 and r11 never leave the unit range.
  `QRM_ASSERT_IMP(a_range, out_valid,
                  (out_r00 <= 16'sd16384) && (out_r00 >= -16'sd16384) &&
                  (out_r11 <= 16'sd16384) && (out_r11 >= -16'sd16384))

endmodule

`default_nettype wire

[src/qrm_prod.sv]
// ---------------------------------------------------------------------------
// qrm_prod
// First stage: the ten pairwise products of the components and the zero flag.
// ---------------------------------------------------------------------------
`default_nettype none

module qrm_prod (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic signed [15:0] z,
  input  wire logic signed [15:0] w,
  output qrm_pkg::prod_t          prod_r
);

  qrm_pkg::prod_t prod_nxt;

  always_comb begin
    prod_nxt.xx    = 32'(x) * 32'(x);
    prod_nxt.yy    = 32'(y) * 32'(y);
    prod_nxt.zz    = 32'(z) * 32'(z);
    prod_nxt.ww    = 32'(w) * 32'(w);
    prod_nxt.xy    = 32'(x) * 32'(y);
    prod_nxt.xz    = 32'(x) * 32'(z);
    prod_nxt.xw    = 32'(x) * 32'(w);
    prod_nxt.yz    = 32'(y) * 32'(z);
    prod_nxt.yw    = 32'(y) * 32'(w);
    prod_nxt.zw    = 32'(z) * 32'(w);
    prod_nxt.degen = (x == 16'sd0) && (y == 16'sd0) && (z == 16'sd0) && (w == 16'sd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

`default_nettype wire

[src/qrm_numer.sv]
// ---------------------------------------------------------------------------
// qrm_numer
// Second stage: squared length and the nine signed numerators.
// ---------------------------------------------------------------------------
`default_nettype none

module qrm_numer (
  input  wire logic      clk,
  input  wire logic      en,
  input  qrm_pkg::prod_t prod,
  output qrm_pkg::numer_t numer_r
);

  qrm_pkg::numer_t numer_nxt;
  logic signed [qrm_pkg::NUMW-1:0] xx, yy, zz, ww, xy, xz, xw, yz, yw, zw, nsum;

  always_comb begin
    xx = 35'(prod.xx);
    yy = 35'(prod.yy);
    zz = 35'(prod.zz);
    ww = 35'(prod.ww);
    xy = 35'(prod.xy);
    xz = 35'(prod.xz);
    xw = 35'(prod.xw);
    yz = 35'(prod.yz);
    yw = 35'(prod.yw);
    zw = 35'(prod.zw);
    nsum = xx + yy + zz + ww;
    numer_nxt.n      = nsum[qrm_pkg::NORMW-1:0];
    // Diagonal entries are n - 2(a+b), rewritten as sums of four squares.
    numer_nxt.num[0] = xx + ww - yy - zz;
    numer_nxt.num[1] = (xy - zw) <<< 1;
    numer_nxt.num[2] = (xz + yw) <<< 1;
    numer_nxt.num[3] = (xy + zw) <<< 1;
    numer_nxt.num[4] = yy + ww - xx - zz;
    numer_nxt.num[5] = (yz - xw) <<< 1;
    numer_nxt.num[6] = (xz - yw) <<< 1;
    numer_nxt.num[7] = (yz + xw) <<< 1;
    numer_nxt.num[8] = zz + ww - xx - yy;
    numer_nxt.degen  = prod.degen;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      numer_r <= numer_nxt;
    end
  end

endmodule

`default_nettype wire

[src/qrm_prep.sv]
// ---------------------------------------------------------------------------
// qrm_prep
// Third stage: sign and magnitude split and the rounded dividend setup.
// ---------------------------------------------------------------------------
`default_nettype none

module qrm_prep (
  input  wire logic       clk,
  input  wire logic       en,
  input  qrm_pkg::numer_t numer,
  output qrm_pkg::div_t   div_r
);

  qrm_pkg::div_t div_nxt;
  logic signed [qrm_pkg::NUMW-1:0] s, m;

  // Dividend is mag * 2^15 + n against divisor 2n, which rounds to nearest.
  always_comb begin
    div_nxt.d     = {1'b0, numer.n} << 1;
    div_nxt.degen = numer.degen;
    div_nxt.q     = '0;
    for (int i = 0; i < qrm_pkg::NENT; i++) begin
      s              = $signed(numer.num[i]);
      m              = s[qrm_pkg::NUMW-1] ? -s : s;
      div_nxt.neg[i] = s[qrm_pkg::NUMW-1];
      div_nxt.rem[i] = {1'b0, m[qrm_pkg::NORMW-1:0], 15'b0} + 49'(numer.n);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

endmodule

`default_nettype wire

[src/qrm_div_stage.sv]
// ---------------------------------------------------------------------------
// qrm_div_stage
// One restoring division step for all nine entries, one quotient bit.
// ---------------------------------------------------------------------------
`default_nettype none

module qrm_div_stage #(
  parameter int unsigned Bit = 0
) (
  input  wire logic     clk,
  input  wire logic     en,
  input  qrm_pkg::div_t div_i,
  output qrm_pkg::div_t div_r
);

  qrm_pkg::div_t div_nxt;
  logic [qrm_pkg::REMW-1:0] trial;

  always_comb begin
    div_nxt = div_i;
    trial   = 49'(div_i.d) << Bit;
    for (int i = 0; i < qrm_pkg::NENT; i++) begin
      if (div_i.rem[i] >= trial) begin
        div_nxt.rem[i]    = div_i.rem[i] - trial;
        div_nxt.q[i][Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

endmodule

`default_nettype wire

[src/qrm_out.sv]
// ---------------------------------------------------------------------------
// qrm_out
// Final stage: clamp, restore sign and zero the degenerate case.
// ---------------------------------------------------------------------------
`default_nettype none

module qrm_out (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  qrm_pkg::div_t             div_i,
  output logic [qrm_pkg::NENT-1:0][15:0] ent_r,
  output logic                      degen_r
);

  logic [qrm_pkg::NENT-1:0][15:0] ent_nxt;
  logic [qrm_pkg::QBITS-1:0]      qv;
  logic [15:0]                    mag;

  always_comb begin
    for (int i = 0; i < qrm_pkg::NENT; i++) begin
      qv  = (div_i.q[i] > 15'(qrm_pkg::QONE)) ? 15'(qrm_pkg::QONE) : div_i.q[i];
      mag = {1'b0, qv};
      if (div_i.degen) begin
        ent_nxt[i] = '0;
      end else if (div_i.neg[i]) begin
        ent_nxt[i] = -mag;
      end else begin
        ent_nxt[i] = mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r   <= ent_nxt;
      degen_r <= div_i.degen;
    end
  end

endmodule

`default_nettype wire

[verif/quaternion_to_rotation_matrix_tb.sv]
// ---------------------------------------------------------------------------
// quaternion_to_rotation_matrix_tb
// Drives quaternions through the rotation matrix pipeline and compares every
// matrix entry and the zero-length flag against a bit-exact local predictor.
// ---------------------------------------------------------------------------
`default_nettype none

module quaternion_to_rotation_matrix_tb;

  // One expected matrix: nine Q1.14 entries in row order and the flag.
  typedef struct {
    logic signed [15:0] ent [9];
    logic               degen;
  } matrix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_quat_x = '0;
  logic signed [15:0] in_quat_y = '0;
  logic signed [15:0] in_quat_z = '0;
  logic signed [15:0] in_quat_w = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_r00, out_r01, out_r02, out_r10, out_r11, out_r12;
  logic signed [15:0] out_r20, out_r21, out_r22;
  logic out_degenerate;

  matrix_t expected_matrices[$];
  int unsigned error_count = 0;
  // Idle rates, in cycles out of a hundred.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  always #6 clk = ~clk;

  quaternion_to_rotation_matrix i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_quat_x(in_quat_x), .in_quat_y(in_quat_y),
    .in_quat_z(in_quat_z), .in_quat_w(in_quat_w),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_r00(out_r00), .out_r01(out_r01), .out_r02(out_r02),
    .out_r10(out_r10), .out_r11(out_r11), .out_r12(out_r12),
    .out_r20(out_r20), .out_r21(out_r21), .out_r22(out_r22),
    .out_degenerate(out_degenerate)
  );

  // Rounds num * 16384 / n to nearest, ties away from zero, and clamps to one.
  function automatic logic signed [15:0] q14_ratio(longint num, longint n);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag * 16384 + n) / (2 * n);
    if (q > 16384) q = 16384;
    return (num < 0) ? 16'(-q) : 16'(q);
  endfunction

  // Works out the normalised rotation matrix of one quaternion.
  function automatic matrix_t rotation_of(logic signed [15:0] qx, logic signed [15:0] qy,
                                          logic signed [15:0] qz, logic signed [15:0] qw);
    matrix_t m;
    longint x, y, z, w, n;
    x = qx; y = qy; z = qz; w = qw;
    n = x*x + y*y + z*z + w*w;
    m.degen = (n == 0);
    if (n == 0) begin
      foreach (m.ent[i]) m.ent[i] = '0;
      return m;
    end
    m.ent[0] = q14_ratio(n - 2*(y*y + z*z), n);
    m.ent[1] = q14_ratio(2*(x*y - z*w), n);
    m.ent[2] = q14_ratio(2*(x*z + y*w), n);
    m.ent[3] = q14_ratio(2*(x*y + z*w), n);
    m.ent[4] = q14_ratio(n - 2*(x*x + z*z), n);
    m.ent[5] = q14_ratio(2*(y*z - x*w), n);
    m.ent[6] = q14_ratio(2*(x*z - y*w), n);
    m.ent[7] = q14_ratio(2*(y*z + x*w), n);
    m.ent[8] = q14_ratio(n - 2*(x*x + y*y), n);
    return m;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Offers one quaternion and holds it steady until the transfer takes place.
  // Valid stays high straight into the next quaternion when no idle falls.
  task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                           logic signed [15:0] qz, logic signed [15:0] qw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_quat_x <= qx; in_quat_y <= qy; in_quat_z <= qz; in_quat_w <= qw;
    do @(posedge clk); while (!in_ready);
    expected_matrices.push_back(rotation_of(qx, qy, qz, qw));
  endtask

  // The receiver stalls at random; every transfer on the result side is
  // checked against the oldest outstanding prediction.
  always @(posedge clk) begin
    matrix_t m;
    logic signed [15:0] got [9];
    if (rst_n && out_valid && out_ready) begin
      got = '{out_r00, out_r01, out_r02, out_r10, out_r11, out_r12,
              out_r20, out_r21, out_r22};
      if (expected_matrices.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        m = expected_matrices.pop_front();
        foreach (got[i])
          if (got[i] !== m.ent[i])
            report_mismatch($sformatf("r%0d%0d", i / 3, i % 3), got[i], m.ent[i]);
        if (out_degenerate !== m.degen)
          report_mismatch("degenerate", out_degenerate, m.degen);
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Extremes of each field, the zero-length case and the axis rotations.
  task automatic test_directed();
    send_quat(0, 0, 0, 0);
    send_quat(0, 0, 0, 1);
    send_quat(0, 0, 0, -1);
    send_quat(1, 0, 0, 0);
    send_quat(0, 1, 0, 0);
    send_quat(0, 0, 1, 0);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, 0, 0, 0);
    send_quat(0, -32768, 0, 0);
    send_quat(0, 0, -32768, 0);
    send_quat(0, 0, 0, -32768);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(-1, -1, -1, -1);
    send_quat(1, 1, 0, 0);
    send_quat(0, 1, 0, 1);
    send_quat(23170, 0, 0, 23170);
    send_quat(1, 2, 3, 4);
    send_quat(-32768, 32767, 1, -1);
    send_quat(-21846, 21845, -5461, 5461);
  endtask

  // Random quaternions: full range for most, small magnitudes for rounding
  // ties, and a few single-axis or zero-length inputs.
  task automatic test_random(int unsigned count);
    logic signed [15:0] q [4];
    repeat (count) begin
      case ($urandom_range(9))
        0, 1: foreach (q[i]) q[i] = 16'($signed($urandom_range(6)) - 3);
        2: begin
          foreach (q[i]) q[i] = '0;
          q[$urandom_range(3)] = 16'($urandom);
        end
        default: foreach (q[i]) q[i] = 16'($urandom);
      endcase
      send_quat(q[0], q[1], q[2], q[3]);
    end
  endtask

  task automatic test_idle_mix(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    test_random(480);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 24;
    recv_stall_pct = 83;
    test_directed();
    test_idle_mix(24, 83);
    test_idle_mix(83, 24);
    test_idle_mix(0, 0);
    in_valid <= 1'b0;
    while (expected_matrices.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Generous bound: roughly 1500 quaternions at the worst stall rates.
  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
